FILE: hw/rtl/scfd_pkg.sv
`timescale 1ns / 1ps

package scfd_pkg;

    // command bytes
    localparam logic [7:0] CMD_SPEED_0 = 8'hAA;
    localparam logic [7:0] CMD_SPEED_1 = 8'hAB;
    localparam logic [7:0] CMD_SPEED_2 = 8'hAC;
    localparam logic [7:0] CMD_TIME_0  = 8'hFA;
    localparam logic [7:0] CMD_TIME_1  = 8'hFB;
    localparam logic [7:0] CMD_TIME_2  = 8'hFC;
    localparam logic [7:0] CMD_DIST_0  = 8'hEA;
    localparam logic [7:0] CMD_DIST_1  = 8'hEB;
    localparam logic [7:0] CMD_DIST_2  = 8'hEC;
    localparam logic [7:0] CMD_START   = 8'hBA;
    localparam logic [7:0] CMD_STOP    = 8'hBB;

    // setting slots
    localparam logic [3:0] SLOT_SPEED_0 = 4'd0;
    localparam logic [3:0] SLOT_SPEED_1 = 4'd1;
    localparam logic [3:0] SLOT_SPEED_2 = 4'd2;
    localparam logic [3:0] SLOT_TIME_0  = 4'd3;
    localparam logic [3:0] SLOT_TIME_1  = 4'd4;
    localparam logic [3:0] SLOT_TIME_2  = 4'd5;
    localparam logic [3:0] SLOT_DIST_0  = 4'd6;
    localparam logic [3:0] SLOT_DIST_1  = 4'd7;
    localparam logic [3:0] SLOT_DIST_2  = 4'd8;
    localparam logic [3:0] SLOT_NONE    = 4'd9;

    localparam int unsigned NUM_SLOTS = 9;

    localparam logic [NUM_SLOTS-1:0] MARKS_TIMED = 9'h03F;
    localparam logic [NUM_SLOTS-1:0] MARKS_DIST  = 9'h1C7;

    // frame byte positions
    localparam logic [1:0] POS_CMD  = 2'd0;
    localparam logic [1:0] POS_LOW  = 2'd1;
    localparam logic [1:0] POS_HIGH = 2'd2;
    localparam logic [1:0] POS_FULL = 2'd3;

    // configuration register map
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic        REG_END_MARKER = 1'b0;
    localparam logic [7:0]  END_MARKER_RESET = 8'hFF;

    localparam int unsigned OUT_DATA_W = 24;

    // frame view after the current byte has been stored
    typedef struct packed {
        logic        is_end;
        logic [7:0]  cmd;
        logic [15:0] value;
    } frame_t;

    typedef struct packed {
        logic        led_off;
        logic        drive_enable;
        logic        distance_run_ready;
        logic        timed_run_ready;
        logic [15:0] frame_value;
        logic [3:0]  slot_written;
    } result_t;

    function automatic logic [3:0] slot_of(input logic [7:0] cmd);
        logic [3:0] slot;
        case (cmd)
            CMD_SPEED_0: slot = SLOT_SPEED_0;
            CMD_SPEED_1: slot = SLOT_SPEED_1;
            CMD_SPEED_2: slot = SLOT_SPEED_2;
            CMD_TIME_0:  slot = SLOT_TIME_0;
            CMD_TIME_1:  slot = SLOT_TIME_1;
            CMD_TIME_2:  slot = SLOT_TIME_2;
            CMD_DIST_0:  slot = SLOT_DIST_0;
            CMD_DIST_1:  slot = SLOT_DIST_1;
            CMD_DIST_2:  slot = SLOT_DIST_2;
            default:     slot = SLOT_NONE;
        endcase
        return slot;
    endfunction

endpackage

FILE: hw/rtl/scfd_frame_asm.sv
`timescale 1ns / 1ps

module scfd_frame_asm
    import scfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] rx_byte,
    input  logic [7:0] end_marker,
    output frame_t     frame
);

    logic [1:0] pos_reg, pos_next;
    logic [7:0] byte0_reg, byte1_reg, byte2_reg;
    logic [7:0] byte0_next, byte1_next, byte2_next;

    always_comb begin
        byte0_next = (pos_reg == POS_CMD)  ? rx_byte : byte0_reg;
        byte1_next = (pos_reg == POS_LOW)  ? rx_byte : byte1_reg;
        byte2_next = (pos_reg == POS_HIGH) ? rx_byte : byte2_reg;

        frame.is_end = (rx_byte == end_marker);
        frame.cmd    = byte0_next;
        frame.value  = {byte2_next, byte1_next};

        // saturate at the long-frame position, restart after a decode
        if (frame.is_end) begin
            pos_next = POS_CMD;
        end else if (pos_reg != POS_FULL) begin
            pos_next = pos_reg + 2'd1;
        end else begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_CMD;
            byte0_reg <= '0;
            byte1_reg <= '0;
            byte2_reg <= '0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            byte0_reg <= byte0_next;
            byte1_reg <= byte1_next;
            byte2_reg <= byte2_next;
        end
    end

endmodule

FILE: hw/rtl/scfd_cmd_decode.sv
`timescale 1ns / 1ps

module scfd_cmd_decode
    import scfd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    advance,
    input  frame_t  frame,
    output result_t result
);

    logic [NUM_SLOTS-1:0] marks_reg, marks_next;
    logic                 drive_reg, drive_next;
    logic [NUM_SLOTS-1:0] marks_set, marks_after_timed;
    logic [3:0]           slot;
    logic                 timed, dist_done;

    always_comb begin
        slot      = slot_of(frame.cmd);
        marks_set = marks_reg;
        if (slot != SLOT_NONE) begin
            marks_set[slot] = 1'b1;
        end

        // timed group first: it takes the speed marks away from the distance group
        timed             = ((marks_set & MARKS_TIMED) == MARKS_TIMED);
        marks_after_timed = timed ? (marks_set & ~MARKS_TIMED) : marks_set;
        dist_done         = ((marks_after_timed & MARKS_DIST) == MARKS_DIST);
        marks_next        = dist_done ? (marks_after_timed & ~MARKS_DIST) : marks_after_timed;

        drive_next = drive_reg | timed | dist_done;
        if (frame.cmd == CMD_START) begin
            drive_next = 1'b1;
        end
        if (frame.cmd == CMD_STOP) begin
            drive_next = 1'b0;
        end

        result.slot_written       = slot;
        result.frame_value        = frame.value;
        result.timed_run_ready    = timed;
        result.distance_run_ready = dist_done;
        result.drive_enable       = drive_next;
        result.led_off            = timed | (slot == SLOT_SPEED_1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marks_reg <= '0;
            drive_reg <= 1'b0;
        end else if (advance && frame.is_end) begin
            marks_reg <= marks_next;
            drive_reg <= drive_next;
        end
    end

endmodule

FILE: hw/rtl/serial_command_frame_decoder_unit.sv
`timescale 1ns / 1ps

// Serial command frame decoder. Takes one received byte per transfer on the
// s_ channel and emits one result transfer on the m_ channel for each byte
// equal to the end marker (register 0, reset 0xFF); other bytes produce
// nothing. One byte is taken every cycle while results are drained. A byte
// passes an input register, then one pass of frame assembly and command
// decode, then the result register. The result register holds a finished
// frame while the next byte is taken into the input stage.
module serial_command_frame_decoder_unit
    import scfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] slot_written, [19:4] frame_value, [20] timed_run_ready,
    // [21] distance_run_ready, [22] drive_enable, [23] led_off
    output logic [OUT_DATA_W-1:0] m_tdata,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] end_marker_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    logic       advance;
    frame_t     frame;
    result_t    result;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_END_MARKER) ? {24'd0, end_marker_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_marker_reg <= END_MARKER_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_END_MARKER) begin
            end_marker_reg <= pwdata[7:0];
        end
    end

    // process the held byte when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    scfd_frame_asm u_frame_asm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .rx_byte    (in_byte_reg),
        .end_marker (end_marker_reg),
        .frame      (frame)
    );

    scfd_cmd_decode u_cmd_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .frame   (frame),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && frame.is_end) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && frame.is_end) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hw/rtl/scfd_checker.sv
`timescale 1ns / 1ps

module scfd_checker
    import scfd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // nothing is offered right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // the timed group consumes the speed marks, so both groups never fire together
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[20] && m_tdata[21]))
        else $error("both run-ready pulses on one frame");

    // a completed group follows a setting write and leaves the drive enabled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[20] || m_tdata[21]) |-> m_tdata[22] && m_tdata[3:0] != SLOT_NONE)
        else $error("run-ready without setting write or drive enable");

    // the timed group always asks for the indicator off
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[20] |-> m_tdata[23])
        else $error("timed run-ready without led_off");

endmodule

bind serial_command_frame_decoder_unit scfd_checker u_scfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
